/* src/cdt_pkg.sv */
package cdt_pkg;

	// Largest image that the distance store holds.
	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// Field widths.
	localparam int DIM_W = 9;
	localparam int VAL_W = 9;
	localparam int PIX_W = 8;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

	// Reset value of both dimension registers.
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

	// Request kinds on the input stream.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Sequencer states: loading, forward pass, backward pass, readout.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_F_PRIME,
		ST_F_READ,
		ST_F_CALC,
		ST_B_PRIME,
		ST_B_READ,
		ST_B_CALC,
		ST_READOUT
	} cdt_state_t;

endpackage

/* src/chessboard_distance_transform.sv */
// Channel   Direction  Handshake              Content
// s_*       in         s_tvalid / s_tready    s_tuser = kind, s_tdata = pixel
// m_*       out        m_tvalid / m_tready    m_tdata = distance, image_min, image_max;
//                                             m_tlast = last_pixel
// cfg_*     in         cfg_valid / cfg_ready  cfg_index = register, cfg_data = value
//
// A load request writes its pixel to the distance store when it is accepted. A readout
// request passes through the registered read of the distance store, then the output
// register. After the last load the two passes run: each pass gives every row a
// row-start read and every pixel a read, then a compute and write back; no request
// is taken meanwhile.
// Reset clears control state only; the distance store is not cleared.
// A stalled output holds its result and blocks further readout requests.
module chessboard_distance_transform (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cdt_pkg::IN_TDATA_W-1:0] s_tdata,   // [7:0] pixel
	input  logic                           s_tuser,   // [0] kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cdt_pkg::OUT_TDATA_W-1:0] m_tdata,  // [8:0] distance, [9] image_min,
	                                                  // [18:10] image_max, [23:19] zero
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdt_pkg::DIM_W-1:0]      cfg_data
);

	localparam int AW = cdt_pkg::ADDR_W;
	localparam int VW = cdt_pkg::VAL_W;
	localparam int DW = cdt_pkg::DIM_W;

	function automatic logic [VW-1:0] min_val(input logic [VW-1:0] a, input logic [VW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	cdt_pkg::cdt_state_t state_q, state_d;

	logic [DW-1:0]   row_cfg_q, col_cfg_q;
	logic [DW-1:0]   nr, nc, seed;
	logic [2*DW-1:0] total;

	logic [AW-1:0] lp_q, rp_q, idx_q;
	logic [DW-1:0] r_q, c_q;
	logic [VW-1:0] diag_q, vert_q, prev_q;
	logic          prime_q;
	logic [VW-1:0] best_q;
	logic          bg_q;

	logic          pend_s1, last_s1;
	logic          out_valid_q, out_last_q, out_min_q;
	logic [VW-1:0] out_dist_q, out_max_q;

	logic          cfg_write, in_acc, load_acc, rd_acc, load_last, read_last;
	logic          row_end, col_start, top_row, bottom_row, neigh_ok, calc_st;
	logic [VW-1:0] own, neigh, mmin, cand, new_val;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [VW-1:0] wr_data, rd_data_a, rd_data_b;

	// Dimensions in use: zero counts as one, the maximum caps the value.
	always_comb begin
		nr = row_cfg_q;
		if (row_cfg_q == '0) nr = DW'(1);
		else if (32'(row_cfg_q) > cdt_pkg::MAX_ROWS) nr = DW'(cdt_pkg::MAX_ROWS);
		nc = col_cfg_q;
		if (col_cfg_q == '0) nc = DW'(1);
		else if (32'(col_cfg_q) > cdt_pkg::MAX_COLS) nc = DW'(cdt_pkg::MAX_COLS);
		seed = (nr > nc) ? nr : nc;
		total = (2*DW)'(nr) * (2*DW)'(nc);
	end

	// Handshake decode.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;
	assign in_acc    = s_tvalid & s_tready;
	assign load_acc  = in_acc && state_q == cdt_pkg::ST_LOAD && s_tuser == cdt_pkg::KIND_LOAD;
	assign rd_acc    = in_acc && state_q == cdt_pkg::ST_READOUT
	                   && s_tuser == cdt_pkg::KIND_READ;
	assign load_last = (32'(lp_q) + 32'd1) == 32'(total);
	assign read_last = (32'(rp_q) + 32'd1) == 32'(total);

	// Position within the image during the passes.
	assign row_end    = c_q == nc - DW'(1);
	assign col_start  = c_q == '0;
	assign top_row    = r_q == '0;
	assign bottom_row = r_q == nr - DW'(1);
	assign calc_st    = state_q == cdt_pkg::ST_F_CALC || state_q == cdt_pkg::ST_B_CALC;

	// Pass arithmetic. The window holds the diagonal and vertical neighbors from the
	// adjacent row; prev is the pixel just finished in this row; neigh is the fresh read.
	always_comb begin
		own = rd_data_a;
		if (state_q == cdt_pkg::ST_F_CALC) neigh_ok = !top_row && !row_end;
		else neigh_ok = !bottom_row && !col_start;
		neigh = neigh_ok ? rd_data_b : '0;
		mmin = min_val(min_val(min_val(seed, diag_q), min_val(vert_q, prev_q)), neigh);
		cand = mmin + VW'(1);
		if (own == '0) new_val = '0;
		else if (state_q == cdt_pkg::ST_F_CALC) new_val = cand;
		else new_val = min_val(cand, own);
	end

	// Memory port selection.
	always_comb begin
		wr_en   = load_acc || (calc_st && own != '0);
		wr_addr = load_acc ? lp_q : idx_q;
		wr_data = load_acc ? VW'(s_tdata[cdt_pkg::PIX_W-1:0]) : new_val;
		rd_addr_a = (state_q == cdt_pkg::ST_READOUT) ? rp_q : idx_q;
		case (state_q)
			cdt_pkg::ST_F_PRIME: rd_addr_b = AW'(int'(idx_q) - int'(nc));
			cdt_pkg::ST_F_READ:  rd_addr_b = AW'(int'(idx_q) - int'(nc) + 1);
			cdt_pkg::ST_B_PRIME: rd_addr_b = AW'(int'(idx_q) + int'(nc));
			cdt_pkg::ST_B_READ:  rd_addr_b = AW'(int'(idx_q) + int'(nc) - 1);
			default:             rd_addr_b = idx_q;
		endcase
	end

	cdt_ram #(
		.WIDTH(VW),
		.DEPTH(cdt_pkg::STORE_DEPTH)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_data_a(rd_data_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_b(rd_data_b)
	);

	// Next state and input ready.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			cdt_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				if (load_acc && load_last) state_d = cdt_pkg::ST_F_PRIME;
			end
			cdt_pkg::ST_F_PRIME: state_d = cdt_pkg::ST_F_READ;
			cdt_pkg::ST_F_READ:  state_d = cdt_pkg::ST_F_CALC;
			cdt_pkg::ST_F_CALC: begin
				if (!row_end) state_d = cdt_pkg::ST_F_READ;
				else if (bottom_row) state_d = cdt_pkg::ST_B_PRIME;
				else state_d = cdt_pkg::ST_F_PRIME;
			end
			cdt_pkg::ST_B_PRIME: state_d = cdt_pkg::ST_B_READ;
			cdt_pkg::ST_B_READ:  state_d = cdt_pkg::ST_B_CALC;
			cdt_pkg::ST_B_CALC: begin
				if (!col_start) state_d = cdt_pkg::ST_B_READ;
				else if (top_row) state_d = cdt_pkg::ST_READOUT;
				else state_d = cdt_pkg::ST_B_PRIME;
			end
			cdt_pkg::ST_READOUT: begin
				s_tready = !pend_s1 && (!out_valid_q || m_tready);
				if (rd_acc && read_last) state_d = cdt_pkg::ST_LOAD;
			end
			default: state_d = cdt_pkg::ST_LOAD;
		endcase
		if (cfg_write) state_d = cdt_pkg::ST_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdt_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: dimensions, positions, image statistics, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cfg_q   <= cdt_pkg::DIM_RESET;
			col_cfg_q   <= cdt_pkg::DIM_RESET;
			lp_q        <= '0;
			rp_q        <= '0;
			best_q      <= '0;
			bg_q        <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					cdt_pkg::REG_ROW_COUNT: row_cfg_q <= cfg_data;
					cdt_pkg::REG_COL_COUNT: col_cfg_q <= cfg_data;
					default: ;
				endcase
				lp_q <= '0;
				rp_q <= '0;
			end else begin
				if (load_acc) lp_q <= load_last ? '0 : lp_q + AW'(1);
				if (rd_acc) rp_q <= read_last ? '0 : rp_q + AW'(1);
			end
			// Statistics restart with the backward pass and collect over it.
			if (state_q == cdt_pkg::ST_F_CALC && row_end && bottom_row) begin
				best_q <= '0;
				bg_q   <= 1'b0;
			end else if (state_q == cdt_pkg::ST_B_CALC) begin
				if (own == '0) bg_q <= 1'b1;
				else if (new_val > best_q) best_q <= new_val;
			end
			pend_s1 <= rd_acc;
			if (pend_s1) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Pass sequencing and the neighbor window.
	always_ff @(posedge clk) begin
		unique case (state_q)
			cdt_pkg::ST_LOAD: begin
				r_q   <= '0;
				c_q   <= '0;
				idx_q <= '0;
			end
			cdt_pkg::ST_F_PRIME, cdt_pkg::ST_B_PRIME: begin
				diag_q  <= '0;
				prev_q  <= '0;
				prime_q <= 1'b1;
			end
			cdt_pkg::ST_F_READ: begin
				if (prime_q) vert_q <= top_row ? '0 : rd_data_b;
				prime_q <= 1'b0;
			end
			cdt_pkg::ST_B_READ: begin
				if (prime_q) vert_q <= bottom_row ? '0 : rd_data_b;
				prime_q <= 1'b0;
			end
			cdt_pkg::ST_F_CALC: begin
				diag_q <= vert_q;
				vert_q <= neigh;
				prev_q <= new_val;
				if (row_end && bottom_row) begin
					r_q   <= nr - DW'(1);
					c_q   <= nc - DW'(1);
					idx_q <= AW'(32'(total) - 32'd1);
				end else if (row_end) begin
					r_q   <= r_q + DW'(1);
					c_q   <= '0;
					idx_q <= idx_q + AW'(1);
				end else begin
					c_q   <= c_q + DW'(1);
					idx_q <= idx_q + AW'(1);
				end
			end
			cdt_pkg::ST_B_CALC: begin
				diag_q <= vert_q;
				vert_q <= neigh;
				prev_q <= new_val;
				idx_q  <= idx_q - AW'(1);
				if (col_start) begin
					r_q <= r_q - DW'(1);
					c_q <= nc - DW'(1);
				end else begin
					c_q <= c_q - DW'(1);
				end
			end
			default: ;
		endcase
	end

	// Readout pipeline: store read, then output register.
	always_ff @(posedge clk) begin
		if (rd_acc) last_s1 <= read_last;
		if (pend_s1) begin
			out_dist_q <= rd_data_a;
			out_last_q <= last_s1;
			out_min_q  <= ~bg_q;
			out_max_q  <= best_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(cdt_pkg::OUT_TDATA_W - 2*VW - 1)'(0), out_max_q, out_min_q, out_dist_q};

endmodule

/* src/cdt_ram.sv */
module cdt_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule
